@@ src/journal_header_validator_unit_macros.svh @@
// Assertion macros shared by the journal header validator RTL.
// No dependencies; expects signals named clk and rst_n in the using module.
`ifndef JOURNAL_HEADER_VALIDATOR_UNIT_MACROS_SVH
`define JOURNAL_HEADER_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JHV_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("journal header validator check failed");

// Next-cycle implication, checked outside reset.
`define JHV_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("journal header validator check failed");

`endif

@@ src/jhv_pkg.sv @@
// Package for the journal header validator: header layout, codes, types and
// the CRC-32C byte update. No dependencies.
package jhv_pkg;

  localparam int IDX_W = 5;

  // Byte offsets of the header fields.
  localparam logic [IDX_W-1:0] OFS_VERSION  = 5'd4;
  localparam logic [IDX_W-1:0] OFS_TYPE     = 5'd6;
  localparam logic [IDX_W-1:0] OFS_SEQ      = 5'd8;
  localparam logic [IDX_W-1:0] OFS_LEN      = 5'd16;
  localparam logic [IDX_W-1:0] LEN_LAST     = 5'd19;
  localparam logic [IDX_W-1:0] CRC_SPAN     = 5'd20;
  localparam logic [IDX_W-1:0] HEADER_BYTES = 5'd24;

  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

  // Result codes.
  localparam int OUTCOME_W = 3;
  localparam logic [OUTCOME_W-1:0] OUT_OK          = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MALFORMED   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_CORRUPT     = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_UNSUPPORTED = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_INVALID     = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_OVERSIZED   = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_VERSION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD_TYPE = 2'd3;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] format_version;
    logic [31:0] payload_limit;
    logic [15:0] max_record_type;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    magic_word:      32'h0,
    format_version:  16'h0,
    payload_limit:   32'hFFFF_FFFF,
    max_record_type: 16'h0
  };

  typedef struct packed {
    logic [IDX_W-1:0] byte_idx;
    logic [31:0]      running_crc;
    logic [31:0]      magic;
    logic [15:0]      version;
    logic [15:0]      rtype;
    logic [63:0]      seq_num;
    logic [31:0]      length;
    logic [31:0]      crc_field;
    logic             prefix_bad;
  } hdr_t;

  localparam hdr_t HDR_CLEAR = '{
    byte_idx:    '0,
    running_crc: CRC_INIT,
    magic:       '0,
    version:     '0,
    rtype:       '0,
    seq_num:     '0,
    length:      '0,
    crc_field:   '0,
    prefix_bad:  1'b0
  };

  // One byte of reflected CRC-32C: eight shift-and-xor steps.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ src/jhv_hdr.sv @@
// Header capture state for the journal header validator: byte counter,
// running CRC and field capture. Depends on jhv_pkg.
module jhv_hdr (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  jhv_pkg::cfg_t cfg,
  output jhv_pkg::hdr_t hdr_nxt
);
  import jhv_pkg::*;

  hdr_t hdr_r;

  // State after taking this byte; the result is judged from these values.
  always_comb begin
    logic [IDX_W-1:0] idx;
    idx     = hdr_r.byte_idx;
    hdr_nxt = hdr_r;
    if (idx < HEADER_BYTES) begin
      if (idx < OFS_VERSION) begin
        hdr_nxt.magic[{idx[1:0], 3'b000} +: 8] =
          hdr_r.magic[{idx[1:0], 3'b000} +: 8] | data_byte;
        if (data_byte != cfg.magic_word[{idx[1:0], 3'b000} +: 8]) begin
          hdr_nxt.prefix_bad = 1'b1;
        end
      end else if (idx < OFS_TYPE) begin
        hdr_nxt.version[{idx[0], 3'b000} +: 8] =
          hdr_r.version[{idx[0], 3'b000} +: 8] | data_byte;
        if (data_byte != cfg.format_version[{idx[0], 3'b000} +: 8]) begin
          hdr_nxt.prefix_bad = 1'b1;
        end
      end else if (idx < OFS_SEQ) begin
        hdr_nxt.rtype[{idx[0], 3'b000} +: 8] =
          hdr_r.rtype[{idx[0], 3'b000} +: 8] | data_byte;
      end else if (idx < OFS_LEN) begin
        hdr_nxt.seq_num[{idx[2:0], 3'b000} +: 8] =
          hdr_r.seq_num[{idx[2:0], 3'b000} +: 8] | data_byte;
      end else if (idx < CRC_SPAN) begin
        hdr_nxt.length[{idx[1:0], 3'b000} +: 8] =
          hdr_r.length[{idx[1:0], 3'b000} +: 8] | data_byte;
        if (idx == LEN_LAST && hdr_nxt.length > cfg.payload_limit) begin
          hdr_nxt.prefix_bad = 1'b1;
        end
      end else begin
        hdr_nxt.crc_field[{idx[1:0], 3'b000} +: 8] =
          hdr_r.crc_field[{idx[1:0], 3'b000} +: 8] | data_byte;
      end
      if (idx < CRC_SPAN) begin
        hdr_nxt.running_crc = crc32c_byte(hdr_r.running_crc, data_byte);
      end
      hdr_nxt.byte_idx = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HDR_CLEAR;
    end else if (step) begin
      hdr_r <= last_byte ? HDR_CLEAR : hdr_nxt;
    end
  end

endmodule

@@ src/jhv_judge.sv @@
// Outcome decision for a completed journal header, in priority order.
// Depends on jhv_pkg.
module jhv_judge (
  input  jhv_pkg::hdr_t                     hdr,
  input  jhv_pkg::cfg_t                     cfg,
  output logic [jhv_pkg::OUTCOME_W-1:0]     outcome
);
  import jhv_pkg::*;

  always_comb begin
    if (hdr.byte_idx < HEADER_BYTES) begin
      outcome = OUT_MALFORMED;
    end else if (hdr.magic != cfg.magic_word) begin
      outcome = OUT_CORRUPT;
    end else if (hdr.version != cfg.format_version) begin
      outcome = OUT_UNSUPPORTED;
    end else if (hdr.rtype == '0 || hdr.rtype > cfg.max_record_type) begin
      outcome = OUT_INVALID;
    end else if (hdr.length > cfg.payload_limit) begin
      outcome = OUT_OVERSIZED;
    end else if ((hdr.running_crc ^ CRC_INIT) != hdr.crc_field) begin
      outcome = OUT_CORRUPT;
    end else begin
      outcome = OUT_OK;
    end
  end

endmodule

@@ src/journal_header_validator_unit.sv @@
// Top level of the journal header validator: input register, header capture,
// verdict and result register. Depends on jhv_pkg, jhv_hdr, jhv_judge and
// journal_header_validator_unit_macros.svh.
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid / in_stall  one header byte and its end mark
//   out_      output     out_valid/out_stall  one verdict with decoded fields
//   cfg_      input      cfg_valid/cfg_ready  register index and write data
//
// Each byte is taken into an input register; from there the CRC-32C byte
// update, field capture and verdict are worked out in one pass and written to
// the header state and, for a final byte, the result register, so one byte
// enters every cycle while the input does not stall. The result of a final byte
// passes the input register and then the result register before it is valid.
// Reset clears the header state and the valid flags and resets the configuration.
// The input stalls only when a final byte waits in the input register while an
// earlier result is still held in the result register.
`include "journal_header_validator_unit_macros.svh"

module journal_header_validator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Byte input.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  // Result output.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [jhv_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic                              out_prefix_ok,
  output logic [15:0]                       out_version_seen,
  output logic [15:0]                       out_record_type,
  output logic [63:0]                       out_sequence_res,
  output logic [31:0]                       out_payload_length,
  output logic [31:0]                       out_stored_crc,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jhv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import jhv_pkg::*;

  cfg_t cfg_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  logic       out_valid_r;
  logic [OUTCOME_W-1:0] outcome_r;
  logic       prefix_ok_r;
  logic [15:0] version_r;
  logic [15:0] rtype_r;
  logic [63:0] sequence_r;
  logic [31:0] length_r;
  logic [31:0] crc_field_r;

  logic       out_free;
  logic       s1_go;
  logic       s1_load;
  hdr_t       hdr_nxt;
  logic [OUTCOME_W-1:0] outcome_nxt;

  // Configuration is always accepted; the user must write it only while the block is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGIC_WORD:      cfg_r.magic_word      <= cfg_data;
        CFG_FORMAT_VERSION:  cfg_r.format_version  <= cfg_data[15:0];
        CFG_PAYLOAD_LIMIT:   cfg_r.payload_limit   <= cfg_data;
        CFG_MAX_RECORD_TYPE: cfg_r.max_record_type <= cfg_data[15:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // The result register can take a new verdict if it is empty or being emptied.
  assign out_free = !out_valid_r || !out_stall;
  // A byte in the input register moves on unless it ends a header and no
  // result slot is free; bytes mid-header never need the result register.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign s1_load  = !s1_valid_r || s1_go;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  jhv_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .hdr_nxt   (hdr_nxt)
  );

  jhv_judge u_judge (
    .hdr     (hdr_nxt),
    .cfg     (cfg_r),
    .outcome (outcome_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The decoded fields go out whatever the outcome is.
  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      outcome_r   <= outcome_nxt;
      prefix_ok_r <= !hdr_nxt.prefix_bad;
      version_r   <= hdr_nxt.version;
      rtype_r     <= hdr_nxt.rtype;
      sequence_r  <= hdr_nxt.seq_num;
      length_r    <= hdr_nxt.length;
      crc_field_r <= hdr_nxt.crc_field;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_prefix_ok      = prefix_ok_r;
  assign out_version_seen   = version_r;
  assign out_record_type    = rtype_r;
  assign out_sequence_res   = sequence_r;
  assign out_payload_length = length_r;
  assign out_stored_crc     = crc_field_r;

  // A stall must come only from a final byte blocked by a held result.
  `JHV_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && s1_last_r && out_valid_r && out_stall)
  // A final byte that moves on always yields a result in the next cycle.
  `JHV_ASSERT_NEXT(a_result_follows, s1_go && s1_last_r, out_valid_r)
  // Only defined result codes ever leave the block.
  `JHV_ASSERT_NOW(a_outcome_legal, out_valid_r, outcome_r <= OUT_OVERSIZED)

endmodule

@@ tb/journal_header_validator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for journal_header_validator_unit: byte-stream headers in,
// verdicts with decoded fields out, compared against an in-bench header checker.
// Depends on jhv_pkg and the journal_header_validator_unit RTL.
module journal_header_validator_unit_tb;
  import jhv_pkg::*;

  // The longest quiet stretch of a correct run is the deliberate receiver
  // hold-off plus a random stall run, so the watchdog sits well above that.
  localparam int WATCHDOG_LIMIT = 4000;
  // Margin for a final byte to pass the input register and reach the result register.
  localparam int DRAIN_CYCLES   = 6;
  localparam int PHASES         = 9;
  localparam int PHASE_BYTES    = 62;
  localparam int HOLD_PHASE     = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_HEADERS   = 24;
  localparam int MAX_SPAN       = 30;

  // Shapes of header that the stimulus can produce.
  typedef enum int {
    HDR_GOOD, HDR_SHORT, HDR_LONG, HDR_BAD_MAGIC, HDR_BAD_VERSION,
    HDR_BAD_TYPE, HDR_OVERSIZE, HDR_BAD_CRC, HDR_NOISE
  } hdr_kind_e;

  // One item of the byte channel.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // One verdict as the result channel should present it.
  typedef struct {
    logic [OUTCOME_W-1:0] outcome;
    logic                 prefix_ok;
    logic [15:0]          version;
    logic [15:0]          rtype;
    logic [63:0]          seq_num;
    logic [31:0]          length;
    logic [31:0]          crc_field;
  } verdict_t;

  // The header as captured so far by the checker in this bench.
  typedef struct {
    int unsigned count;
    logic [31:0] crc;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] rtype;
    logic [63:0] seq_num;
    logic [31:0] length;
    logic [31:0] crc_field;
    logic        bad;
  } capture_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 out_prefix_ok;
  logic [15:0]          out_version_seen;
  logic [15:0]          out_record_type;
  logic [63:0]          out_sequence_res;
  logic [31:0]          out_payload_length;
  logic [31:0]          out_stored_crc;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_MAGIC_WORD;
  logic [31:0]          cfg_data     = 32'h0;

  // Register values as the block should hold them; these start at reset values.
  logic [31:0] exp_magic     = 32'h0;
  logic [15:0] exp_version   = 16'h0;
  logic [31:0] limit_payload = 32'hFFFF_FFFF;
  logic [15:0] limit_type    = 16'h0;

  capture_t   hdr_cap;
  verdict_t   expected_verdicts[$];
  byte_item_t byte_queue[$];
  // Tail of a header that is split across a register change.
  byte_item_t carry_q[$];
  int         bytes_pending  = 0;
  int         bytes_queued   = 0;
  int         mismatches     = 0;
  int         quiet_cycles   = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         stall_hold     = 0;
  bit         in_taken       = 1'b0;

  journal_header_validator_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_prefix_ok      (out_prefix_ok),
    .out_version_seen   (out_version_seen),
    .out_record_type    (out_record_type),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_stored_crc     (out_stored_crc),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reflected CRC-32C, one data bit at a time, least significant bit first.
  function automatic logic [31:0] crc32c_update(input logic [31:0] state,
                                                input logic [7:0]  octet);
    logic [31:0] r;
    logic        fb;
    r = state;
    for (int b = 0; b < 8; b++) begin
      fb = r[0] ^ octet[b];
      r  = r >> 1;
      if (fb) r = r ^ CRC32C_POLY;
    end
    return r;
  endfunction

  function automatic capture_t fresh_capture();
    capture_t h;
    h.count     = 0;
    h.crc       = CRC_INIT;
    h.magic     = '0;
    h.version   = '0;
    h.rtype     = '0;
    h.seq_num   = '0;
    h.length    = '0;
    h.crc_field = '0;
    h.bad       = 1'b0;
    return h;
  endfunction

  // The verdict is decided in a fixed order: length of the header first, then
  // magic, version, type domain, payload limit and finally the header CRC.
  function automatic verdict_t judge_header(input capture_t h);
    verdict_t v;
    v.prefix_ok = !h.bad;
    v.version   = h.version;
    v.rtype     = h.rtype;
    v.seq_num   = h.seq_num;
    v.length    = h.length;
    v.crc_field = h.crc_field;
    if (h.count < HEADER_BYTES) v.outcome = OUT_MALFORMED;
    else if (h.magic != exp_magic) v.outcome = OUT_CORRUPT;
    else if (h.version != exp_version) v.outcome = OUT_UNSUPPORTED;
    else if (h.rtype == 16'h0 || h.rtype > limit_type) v.outcome = OUT_INVALID;
    else if (h.length > limit_payload) v.outcome = OUT_OVERSIZED;
    else if (~h.crc != h.crc_field) v.outcome = OUT_CORRUPT;
    else v.outcome = OUT_OK;
    return v;
  endfunction

  // Takes one accepted byte into the captured header. Bytes past the end of the
  // header are dropped, but a final mark on one of them still closes the header.
  // The prefix checks use the register values at the time each byte arrives.
  task automatic absorb_byte(input logic [7:0] octet, input logic final_mark);
    int unsigned pos;
    pos = hdr_cap.count;
    if (pos < HEADER_BYTES) begin
      if (pos < OFS_VERSION) begin
        hdr_cap.magic[8*pos +: 8] = octet;
        if (octet != exp_magic[8*pos +: 8]) hdr_cap.bad = 1'b1;
      end else if (pos < OFS_TYPE) begin
        hdr_cap.version[8*(pos-OFS_VERSION) +: 8] = octet;
        if (octet != exp_version[8*(pos-OFS_VERSION) +: 8]) hdr_cap.bad = 1'b1;
      end else if (pos < OFS_SEQ) begin
        hdr_cap.rtype[8*(pos-OFS_TYPE) +: 8] = octet;
      end else if (pos < OFS_LEN) begin
        hdr_cap.seq_num[8*(pos-OFS_SEQ) +: 8] = octet;
      end else if (pos < CRC_SPAN) begin
        hdr_cap.length[8*(pos-OFS_LEN) +: 8] = octet;
        if (pos == LEN_LAST && hdr_cap.length > limit_payload) hdr_cap.bad = 1'b1;
      end else begin
        hdr_cap.crc_field[8*(pos-CRC_SPAN) +: 8] = octet;
      end
      if (pos < CRC_SPAN) hdr_cap.crc = crc32c_update(hdr_cap.crc, octet);
      hdr_cap.count = pos + 1;
    end
    if (final_mark) begin
      expected_verdicts.push_back(judge_header(hdr_cap));
      hdr_cap = fresh_capture();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic last);
    byte_queue.push_back('{data: data, last: last});
    bytes_pending++;
    bytes_queued++;
  endtask

  // Builds a header from the current register values and queues its bytes.
  // A non-zero split holds back every byte from that position on in the carry
  // queue, so that the header is finished after the next register change.
  task automatic queue_header(input hdr_kind_e kind, input int split);
    logic [7:0]  hb [MAX_SPAN];
    logic [15:0] rtype;
    logic [31:0] len;
    logic [31:0] crc;
    logic [63:0] seq_num;
    int          span;
    int          pick;
    for (int i = 0; i < MAX_SPAN; i++) hb[i] = 8'($urandom);
    rtype   = (limit_type == 16'h0) ? 16'($urandom) : 16'($urandom_range(limit_type, 1));
    len     = $urandom_range(limit_payload, 0);
    seq_num = {$urandom, $urandom};
    // Type zero is never valid, so it is one of the two ways to break the type.
    if (kind == HDR_BAD_TYPE)
      rtype = (limit_type == 16'hFFFF || $urandom_range(1) == 0) ?
              16'h0 : 16'($urandom_range(16'hFFFF, 32'(limit_type) + 1));
    if (kind == HDR_OVERSIZE && limit_payload != 32'hFFFF_FFFF)
      len = $urandom_range(32'hFFFF_FFFF, limit_payload + 32'd1);
    if (kind != HDR_NOISE) begin
      for (int i = 0; i < 4; i++) begin
        hb[i]           = exp_magic[8*i +: 8];
        hb[OFS_LEN + i] = len[8*i +: 8];
      end
      for (int i = 0; i < 2; i++) begin
        hb[OFS_VERSION + i] = exp_version[8*i +: 8];
        hb[OFS_TYPE + i]    = rtype[8*i +: 8];
      end
      for (int i = 0; i < 8; i++) hb[OFS_SEQ + i] = seq_num[8*i +: 8];
      if (kind == HDR_BAD_MAGIC) begin
        pick     = $urandom_range(OFS_VERSION - 1);
        hb[pick] = hb[pick] ^ (8'h01 << $urandom_range(7));
      end
      if (kind == HDR_BAD_VERSION) begin
        pick     = OFS_VERSION + $urandom_range(1);
        hb[pick] = hb[pick] ^ (8'h01 << $urandom_range(7));
      end
      crc = CRC_INIT;
      for (int i = 0; i < CRC_SPAN; i++) crc = crc32c_update(crc, hb[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) hb[CRC_SPAN + i] = crc[8*i +: 8];
      if (kind == HDR_BAD_CRC) begin
        pick     = CRC_SPAN + $urandom_range(3);
        hb[pick] = hb[pick] ^ (8'h01 << $urandom_range(7));
      end
    end
    case (kind)
      HDR_SHORT: span = $urandom_range(HEADER_BYTES - 1, 1);
      HDR_LONG:  span = $urandom_range(MAX_SPAN, HEADER_BYTES + 1);
      HDR_NOISE: span = $urandom_range(MAX_SPAN, 1);
      default:   span = HEADER_BYTES;
    endcase
    for (int i = 0; i < span; i++) begin
      if (split > 0 && i >= split) carry_q.push_back('{data: hb[i], last: (i == span - 1)});
      else push_byte(hb[i], i == span - 1);
    end
  endtask

  // About a third well-formed headers with random content; the rest are broken in one
  // place each, cut short, run long, or pure noise.
  function automatic hdr_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return HDR_GOOD;
    if (r < 45) return HDR_SHORT;
    if (r < 53) return HDR_LONG;
    if (r < 60) return HDR_BAD_MAGIC;
    if (r < 67) return HDR_BAD_VERSION;
    if (r < 74) return HDR_BAD_TYPE;
    if (r < 81) return HDR_OVERSIZE;
    if (r < 90) return HDR_BAD_CRC;
    return HDR_NOISE;
  endfunction

  // One register write; the bench copy changes when the write is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAGIC_WORD:      exp_magic     = value;
      CFG_FORMAT_VERSION:  exp_version   = value[15:0];
      CFG_PAYLOAD_LIMIT:   limit_payload = value;
      CFG_MAX_RECORD_TYPE: limit_type    = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Phase zero keeps the reset values; the next two go to opposite extremes and
  // the rest pick random values with an occasional extreme limit.
  task automatic apply_phase_config(input int phase);
    logic [31:0] magic, payload;
    logic [15:0] version, rtype_max;
    case (phase)
      0: return;
      1: begin
        magic = 32'hFFFF_FFFF; version = 16'hFFFF; payload = 32'h0; rtype_max = 16'hFFFF;
      end
      2: begin
        magic = 32'h0; version = 16'h0; payload = 32'hFFFF_FFFF; rtype_max = 16'h1;
      end
      default: begin
        magic     = $urandom;
        version   = 16'($urandom);
        payload   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
        rtype_max = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(16'hFFFF, 1));
      end
    endcase
    write_reg(CFG_MAGIC_WORD, magic);
    write_reg(CFG_FORMAT_VERSION, {16'h0, version});
    write_reg(CFG_PAYLOAD_LIMIT, payload);
    write_reg(CFG_MAX_RECORD_TYPE, {16'h0, rtype_max});
  endtask

  // The block is idle once every queued byte is taken and every verdict has come
  // back; a byte without a final mark can still be in flight, hence the margin.
  task automatic wait_drained();
    while (bytes_pending != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Acceptance on the byte channel: the checker in this bench advances here, and
  // the driver learns at the next falling edge that its item has gone.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      absorb_byte(in_data_byte, in_last_byte);
      bytes_pending--;
    end
  end

  // Byte driver. Once an item is offered it stays unchanged until taken; the
  // decision to idle is made only between items, never in reply to a stall.
  always @(negedge clk) begin
    byte_item_t next_item;
    if (in_valid && !in_taken) begin
      // Still waiting for the block to take the current item.
    end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      next_item = byte_queue.pop_front();
      in_valid     <= 1'b1;
      in_data_byte <= next_item.data;
      in_last_byte <= next_item.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver. A hold-off keeps the stall high for a counted stretch so
  // that the result register stays full and the block has to stall its input.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor: each verdict taken is matched against the oldest one due.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual outcome %0d",
                 $time, out_outcome);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("outcome", want.outcome, out_outcome);
        check_field("prefix_ok", want.prefix_ok, out_prefix_ok);
        check_field("version_seen", want.version, out_version_seen);
        check_field("record_type", want.rtype, out_record_type);
        check_field("sequence_res", want.seq_num, out_sequence_res);
        check_field("payload_length", want.length, out_payload_length);
        check_field("stored_crc", want.crc_field, out_stored_crc);
      end
    end
  end

  // Watchdog: counts cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus. Each phase waits for the block to drain, which doubles as the
  // sender pausing until every verdict has come back, then sets the registers
  // and the idling pattern and queues its headers.
  initial begin
    byte_item_t carried;
    int         target;
    hdr_cap = fresh_capture();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      apply_phase_config(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      // Finish any header that was started before the registers changed; its
      // verdict must use the new values while its prefix used the old ones.
      while (carry_q.size() != 0) begin
        carried = carry_q.pop_front();
        push_byte(carried.data, carried.last);
      end
      if (phase == 0) begin
        // Directed opening: one-byte headers at both byte extremes, then a
        // complete header under the reset values, where no type is valid.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        queue_header(HDR_GOOD, 0);
      end
      if (phase == HOLD_PHASE) begin
        // A burst of one-byte headers behind a long receiver hold-off.
        stall_hold = HOLD_CYCLES;
        repeat (HOLD_HEADERS) push_byte(8'($urandom), 1'b1);
      end
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) queue_header(pick_kind(), 0);
      if (phase < PHASES - 1 && (phase % 2 == 1 || $urandom_range(1) == 1))
        queue_header(HDR_GOOD, $urandom_range(HEADER_BYTES - 1, 1));
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/jhv_pkg.sv
src/jhv_hdr.sv
src/jhv_judge.sv
src/journal_header_validator_unit.sv
tb/journal_header_validator_unit_tb.sv
